### hw/rtl/kts_pkg.sv
// Shared types, constants and the reset contents of the key table.
`timescale 1ns / 1ps
`default_nettype none

package kts_pkg;

	localparam int WORD_AW   = 5;
	localparam int WORD_W    = 64;
	localparam int WORD_CNT  = 32;
	localparam int PW_AW     = 6;
	localparam int PW_DEPTH  = 64;
	localparam int LEN_W     = 7;

	localparam logic [LEN_W-1:0] MAX_PW = 7'd64;
	localparam logic [WORD_AW-1:0] WORD_LAST = 5'd31;
	localparam logic [7:0] POS_LAST = 8'hff;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_DATA    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	typedef struct packed {
		logic [WORD_AW-1:0] rd_addr;
		logic               wr_en;
		logic [WORD_AW-1:0] wr_addr;
		logic [WORD_W-1:0]  wr_data;
		logic               clear;
	} tbl_req_t;

	localparam logic [7:0] TABLE_INIT [0:255] = '{
		8'h9a,8'h36,8'he9,8'h15,8'hda,8'h91,8'h6f,8'h04,
		8'hf9,8'h18,8'h1b,8'h68,8'h28,8'h45,8'hf4,8'ha7,
		8'hff,8'h5a,8'h2f,8'hb5,8'h41,8'h7a,8'h8d,8'h85,
		8'h2c,8'h13,8'h57,8'h3d,8'hb3,8'h53,8'h34,8'hee,
		8'hd8,8'hca,8'hd1,8'h25,8'hc6,8'hc7,8'h2e,8'h33,
		8'h73,8'he3,8'hce,8'h4e,8'hcd,8'h10,8'ha9,8'h5d,
		8'h0f,8'hae,8'h3c,8'h62,8'hba,8'ha8,8'h51,8'h11,
		8'hf2,8'hef,8'h21,8'h0a,8'h0b,8'he4,8'h86,8'h7c,
		8'h87,8'he0,8'h35,8'h07,8'h8b,8'h7f,8'h64,8'h55,
		8'h3e,8'h7e,8'h0e,8'h1a,8'h59,8'haf,8'h8e,8'h54,
		8'hea,8'h1c,8'hd5,8'hf1,8'h8a,8'h01,8'h5b,8'h95,
		8'h96,8'h7b,8'ha1,8'h67,8'h92,8'h7d,8'h6c,8'hbd,
		8'hdd,8'h2d,8'he1,8'h23,8'h47,8'h1e,8'hc5,8'h8c,
		8'hc0,8'ha3,8'h08,8'h4c,8'hb0,8'h6d,8'h9c,8'h80,
		8'h89,8'h94,8'h00,8'hc9,8'h84,8'hd7,8'h5f,8'h4b,
		8'hc3,8'h65,8'he6,8'hab,8'h93,8'h16,8'hf0,8'hb2,
		8'hc2,8'h2b,8'hb7,8'h43,8'h52,8'h09,8'h76,8'h3b,
		8'h56,8'h60,8'h98,8'hb8,8'h32,8'h8f,8'hfe,8'h69,
		8'ha5,8'h88,8'he7,8'h90,8'h99,8'h79,8'h48,8'ha0,
		8'hbc,8'h17,8'h40,8'hd6,8'hb6,8'h75,8'h39,8'h82,
		8'h70,8'h4d,8'h81,8'h20,8'hed,8'hb4,8'h0d,8'h71,
		8'h2a,8'hc8,8'h9d,8'hbb,8'hd4,8'h77,8'hf8,8'hd2,
		8'h29,8'h9e,8'h19,8'hac,8'h42,8'hbf,8'h61,8'hcc,
		8'h38,8'h26,8'h27,8'h83,8'hcb,8'hd9,8'hb9,8'haa,
		8'h9f,8'h37,8'hdb,8'h02,8'h30,8'h44,8'hdc,8'h06,
		8'hf3,8'h74,8'h5c,8'h6b,8'hfa,8'had,8'hd0,8'h3a,
		8'h4f,8'h63,8'hbe,8'h97,8'h50,8'hec,8'h66,8'hc1,
		8'hf7,8'ha4,8'hfc,8'h49,8'he5,8'h14,8'h72,8'h58,
		8'h3f,8'h4a,8'h46,8'h6a,8'hfd,8'ha2,8'h03,8'hb1,
		8'h31,8'hf6,8'hcf,8'hc4,8'h12,8'hfb,8'hf5,8'hde,
		8'h78,8'h9b,8'h05,8'h6e,8'h22,8'h5e,8'h1f,8'ha6,
		8'h24,8'hdf,8'h1d,8'he2,8'he8,8'hd3,8'heb,8'h0c
	};

	function automatic logic [WORD_W-1:0] init_word(input logic [WORD_AW-1:0] addr);
		logic [WORD_W-1:0] w;
		w = '0;
		for (int b = 0; b < 8; b++) begin
			w[8*b +: 8] = TABLE_INIT[{addr, 3'(b)}];
		end
		return w;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/kts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module kts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### hw/rtl/kts_table.sv
// Key table of 32 eight-byte words with per-word valid flags over the reset contents.
`timescale 1ns / 1ps
`default_nettype none

module kts_table import kts_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tbl_req_t          req,
	output logic [WORD_W-1:0]      rd_data
);

	logic [WORD_CNT-1:0] valid_q;
	logic                rd_valid_q;
	logic [WORD_W-1:0]   rd_init_q;
	logic [WORD_W-1:0]   ram_rd_data;

	kts_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORD_CNT)
	) u_ram (
		.clk     (clk),
		.wr_en   (req.wr_en),
		.wr_addr (req.wr_addr),
		.wr_data (req.wr_data),
		.rd_addr (req.rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[req.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		rd_init_q <= init_word(req.rd_addr);
	end

	assign rd_data = rd_valid_q ? ram_rd_data : rd_init_q;

endmodule

`default_nettype wire

### hw/rtl/kts_mod.sv
// Bit-serial remainder unit: byte position modulo password length, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module kts_mod import kts_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [7:0]       dividend,
	input  wire logic [LEN_W-1:0] divisor,
	output logic                  done,
	output logic [PW_AW-1:0]      remainder
);

	logic               busy_q;
	logic               done_q;
	logic [2:0]         cnt_q;
	logic [7:0]         num_q;
	logic [PW_AW-1:0]   rem_q;
	logic [LEN_W-1:0]   trial;
	logic [LEN_W-1:0]   diff;

	assign trial = {rem_q, num_q[7]};
	assign diff  = trial - divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= (trial >= divisor) ? diff[PW_AW-1:0] : trial[PW_AW-1:0];
			num_q <= {num_q[6:0], 1'b0};
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

### hw/rtl/keyed_table_stream_cipher_top.sv
// Top level of the keyed-table byte stream cipher: sequencer, registers and result stage.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    opcode, byte_value, password_index
//  out       source     out_valid / out_ready  data_out
//  cfg       APB slave  psel, penable, pready  paddr, pwdata, prdata
//
// The first byte of each block adds the 32 word swaps on the single table port, each one
// a password read, two word reads and two word writes. After the last byte of a block the
// remap rewrites each password byte in use. A length change first runs the remainder unit.
// Reset and restart revert the table at once through per-word valid flags.
// A full result register that is not taken holds the sequencer in its result state.
`timescale 1ns / 1ps
`default_nettype none

module keyed_table_stream_cipher_top import kts_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  byte_value,
	input  wire logic [5:0]  password_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       data_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_LEN  = 1'b1;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_MOD    = 4'd1;
	localparam logic [3:0] ST_SW_PW  = 4'd2;
	localparam logic [3:0] ST_SW_RA  = 4'd3;
	localparam logic [3:0] ST_SW_RB  = 4'd4;
	localparam logic [3:0] ST_SW_WA  = 4'd5;
	localparam logic [3:0] ST_SW_WB  = 4'd6;
	localparam logic [3:0] ST_DT_RD  = 4'd7;
	localparam logic [3:0] ST_DT_OUT = 4'd8;
	localparam logic [3:0] ST_RM_PW  = 4'd9;
	localparam logic [3:0] ST_RM_TB  = 4'd10;
	localparam logic [3:0] ST_RM_WR  = 4'd11;

	logic [3:0]         state_q;
	logic [3:0]         state_d;
	logic               mode_q;
	logic [LEN_W-1:0]   length_q;
	logic [LEN_W-1:0]   len_eff;
	logic [LEN_W-1:0]   len_seen_q;
	logic               started_q;
	logic [7:0]         k_q;
	logic [PW_AW-1:0]   kmod_q;
	logic [WORD_AW-1:0] j_q;
	logic [PW_AW-1:0]   jmod_q;
	logic [PW_AW-1:0]   i_q;
	logic               out_valid_q;
	logic [7:0]         data_out_q;
	logic [7:0]         byte_q;
	logic [WORD_AW-1:0] other_q;
	logic [WORD_W-1:0]  tmp_q;
	logic [2:0]         sel_q;

	logic               in_fire;
	logic               cfg_write;
	logic               out_load;
	logic               mod_start;
	logic               mod_done;
	logic [PW_AW-1:0]   mod_rem;
	tbl_req_t           tbl_req;
	logic [WORD_W-1:0]  tbl_rd_data;
	logic               pw_wr_en;
	logic [PW_AW-1:0]   pw_wr_addr;
	logic [7:0]         pw_wr_data;
	logic [PW_AW-1:0]   pw_rd_addr;
	logic [7:0]         pw_rd_data;
	logic [7:0]         tbl_byte;
	logic [7:0]         result;
	logic [LEN_W-1:0]   jmod_inc;
	logic [LEN_W-1:0]   kmod_inc;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_write = psel && penable && pwrite;
	assign pready    = 1'b1;
	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;

	always_comb begin
		if (length_q == '0) begin
			len_eff = 7'd1;
		end else if (length_q > MAX_PW) begin
			len_eff = MAX_PW;
		end else begin
			len_eff = length_q;
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE: prdata = {31'b0, mode_q};
			REG_LEN:  prdata = {25'b0, length_q};
			default:  prdata = '0;
		endcase
	end

	kts_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tbl_req),
		.rd_data (tbl_rd_data)
	);

	kts_ram #(
		.WIDTH (8),
		.DEPTH (PW_DEPTH)
	) u_pw_ram (
		.clk     (clk),
		.wr_en   (pw_wr_en),
		.wr_addr (pw_wr_addr),
		.wr_data (pw_wr_data),
		.rd_addr (pw_rd_addr),
		.rd_data (pw_rd_data)
	);

	kts_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (k_q),
		.divisor   (len_eff),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	assign jmod_inc = {1'b0, jmod_q} + 7'd1;
	assign kmod_inc = {1'b0, kmod_q} + 7'd1;

	always_comb begin
		case (state_q)
			ST_DT_OUT: tbl_byte = tbl_rd_data[{k_q[2:0], 3'b000} +: 8];
			default:   tbl_byte = tbl_rd_data[{sel_q, 3'b000} +: 8];
		endcase
		if (mode_q) begin
			result = (byte_q + pw_rd_data) ^ tbl_byte;
		end else begin
			result = (byte_q ^ tbl_byte) - pw_rd_data;
		end
	end

	always_comb begin
		state_d         = state_q;
		tbl_req         = '0;
		tbl_req.rd_addr = j_q;
		pw_rd_addr      = jmod_q;
		pw_wr_en        = 1'b0;
		pw_wr_addr      = password_index;
		pw_wr_data      = byte_value;
		mod_start       = 1'b0;
		out_load        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (opcode)
						OP_LOAD: begin
							pw_wr_en = 1'b1;
						end
						OP_DATA: begin
							if (len_eff != len_seen_q) begin
								mod_start = 1'b1;
								state_d   = ST_MOD;
							end else begin
								state_d = started_q ? ST_DT_RD : ST_SW_PW;
							end
						end
						OP_RESTART: begin
							tbl_req.clear = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					state_d = started_q ? ST_DT_RD : ST_SW_PW;
				end
			end
			ST_SW_PW: begin
				state_d = ST_SW_RA;
			end
			ST_SW_RA: begin
				state_d = ST_SW_RB;
			end
			ST_SW_RB: begin
				tbl_req.rd_addr = other_q;
				state_d         = ST_SW_WA;
			end
			ST_SW_WA: begin
				tbl_req.wr_en   = 1'b1;
				tbl_req.wr_addr = j_q;
				tbl_req.wr_data = tbl_rd_data;
				state_d         = ST_SW_WB;
			end
			ST_SW_WB: begin
				tbl_req.wr_en   = 1'b1;
				tbl_req.wr_addr = other_q;
				tbl_req.wr_data = tmp_q;
				state_d         = (j_q == WORD_LAST) ? ST_DT_RD : ST_SW_PW;
			end
			ST_DT_RD: begin
				tbl_req.rd_addr = k_q[7:3];
				pw_rd_addr      = kmod_q;
				state_d         = ST_DT_OUT;
			end
			ST_DT_OUT: begin
				tbl_req.rd_addr = k_q[7:3];
				pw_rd_addr      = kmod_q;
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = (k_q == POS_LAST) ? ST_RM_PW : ST_IDLE;
				end
			end
			ST_RM_PW: begin
				pw_rd_addr = i_q;
				state_d    = ST_RM_TB;
			end
			ST_RM_TB: begin
				tbl_req.rd_addr = pw_rd_data[7:3];
				state_d         = ST_RM_WR;
			end
			ST_RM_WR: begin
				pw_wr_en   = 1'b1;
				pw_wr_addr = i_q;
				pw_wr_data = tbl_byte;
				state_d    = ({1'b0, i_q} == 7'(len_eff - 7'd1)) ? ST_IDLE : ST_RM_PW;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= 1'b0;
			length_q    <= 7'd1;
			len_seen_q  <= 7'd1;
			started_q   <= 1'b0;
			k_q         <= '0;
			kmod_q      <= '0;
			j_q         <= '0;
			jmod_q      <= '0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (paddr[2])
					REG_MODE: mode_q   <= pwdata[0];
					REG_LEN:  length_q <= pwdata[LEN_W-1:0];
					default:  ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire && opcode == OP_RESTART) begin
				k_q       <= '0;
				kmod_q    <= '0;
				started_q <= 1'b0;
			end
			if (state_q == ST_MOD && mod_done) begin
				kmod_q     <= mod_rem;
				len_seen_q <= len_eff;
			end
			if (state_q == ST_SW_WB) begin
				j_q <= j_q + 5'd1;
				if (j_q == WORD_LAST) begin
					jmod_q    <= '0;
					started_q <= 1'b1;
				end else begin
					jmod_q <= (jmod_inc == len_eff) ? '0 : jmod_inc[PW_AW-1:0];
				end
			end
			if (out_load) begin
				k_q <= k_q + 8'd1;
				if (k_q == POS_LAST) begin
					kmod_q    <= '0;
					started_q <= 1'b0;
					i_q       <= '0;
				end else begin
					kmod_q <= (kmod_inc == len_seen_q) ? '0 : kmod_inc[PW_AW-1:0];
				end
			end
			if (state_q == ST_RM_WR) begin
				i_q <= i_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && opcode == OP_DATA) begin
			byte_q <= byte_value;
		end
		if (state_q == ST_SW_RA) begin
			other_q <= pw_rd_data[WORD_AW-1:0];
		end
		if (state_q == ST_SW_RB) begin
			tmp_q <= tbl_rd_data;
		end
		if (state_q == ST_RM_TB) begin
			sel_q <= pw_rd_data[2:0];
		end
		if (out_load) begin
			data_out_q <= result;
		end
	end

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_eff != 7'd0 && len_eff <= MAX_PW)
		else $error("effective password length out of range");

	a_mod_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> state_q == ST_MOD)
		else $error("remainder unit finished outside its wait state");

	a_swap_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SW_WB && j_q == WORD_LAST) |=> (started_q && state_q == ST_DT_RD))
		else $error("swap pass did not hand over to the data byte");

	a_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && k_q == POS_LAST) |=> (state_q == ST_RM_PW && !started_q && k_q == 8'd0))
		else $error("block end did not start the password remap");

endmodule

`default_nettype wire
